// ===== src/scfc_pkg.sv =====
`default_nettype none
package scfc_pkg;

    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 16;
    localparam int DATA_BYTES  = 2 * CHANNELS;
    localparam int FRAME_BYTES = DATA_BYTES + 2;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef logic [15:0] crc_t;
    typedef crc_t crc_table_t [256];

    typedef struct packed {
        logic [CHANNELS-1:0][CHAN_W-1:0] chan;
        crc_t                            crc;
    } scfc_item_t;

    // Byte-wise lookup table for the reflected polynomial, built at elaboration.
    function automatic crc_table_t crc_build_table();
        crc_table_t t;
        crc_t       c;
        for (int i = 0; i < 256; i++)
        begin
            c = crc_t'(i);
            for (int b = 0; b < 8; b++)
            begin
                if (c[0])
                    c = (c >> 1) ^ CRC_POLY;
                else
                    c = c >> 1;
            end
            t[i] = c;
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_build_table();

    function automatic crc_t crc_feed_byte(crc_t crc, logic [7:0] data);
        logic [7:0] idx;
        idx = crc[7:0] ^ data;
        return (crc >> 8) ^ CRC_TABLE[idx];
    endfunction

endpackage
`default_nettype wire

// ===== src/scfc_stage.sv =====
`default_nettype none
module scfc_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire scfc_pkg::scfc_item_t in_item,
    input  wire logic [15:0]          chan_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output scfc_pkg::scfc_item_t      out_item
);
    import scfc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    scfc_item_t item_reg;
    scfc_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    // One channel per stage: low byte, then high byte.
    always_comb
    begin
        item_next     = in_item;
        item_next.crc = crc_feed_byte(crc_feed_byte(in_item.crc, chan_value[7:0]),
                                      chan_value[15:8]);
    end

    always_comb
    begin
        if (in_ready)
            valid_next = in_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ===== src/scfc_serializer.sv =====
`default_nettype none
module scfc_serializer
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire scfc_pkg::scfc_item_t in_item,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);
    import scfc_pkg::*;

    logic                             busy_reg;
    logic                             busy_next;
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 idx_next;
    logic [FRAME_BYTES-1:0][7:0]      frame_reg;
    logic [FRAME_BYTES-1:0][7:0]      frame_next;
    logic                             take;
    logic                             at_last;
    logic                             load;

    always_comb
    begin
        for (int k = 0; k < DATA_BYTES; k++)
            frame_next[k] = in_item.chan[k / 2][8 * (k % 2) +: 8];
        frame_next[DATA_BYTES]     = in_item.crc[7:0];
        frame_next[DATA_BYTES + 1] = in_item.crc[15:8];
    end

    assign take     = busy_reg && m_tready;
    assign at_last  = (idx_reg == IDX_W'(FRAME_BYTES - 1));
    // Next frame loads as the last byte of the current one leaves.
    assign in_ready = !busy_reg || (m_tready && at_last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        priority if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            busy_next = !at_last;
            idx_next  = at_last ? idx_reg : idx_reg + IDX_W'(1);
        end
        else
        begin
            busy_next = busy_reg;
            idx_next  = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frame_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = frame_reg[idx_reg];
    assign m_tlast  = at_last;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < IDX_W'(FRAME_BYTES)))
        else $error("byte index out of frame");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !at_last) |=> (idx_reg == $past(idx_reg) + IDX_W'(1)))
        else $error("byte index did not advance");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (take && at_last && !in_valid) |=> !busy_reg)
        else $error("serializer stayed busy after last byte");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == '0))
        else $error("frame did not start at first byte");
`endif

endmodule
`default_nettype wire

// ===== src/scope_frame_crc16_encoder.sv =====
`default_nettype none
// Telemetry frame encoder with CRC-16 (Modbus form).
// Slave channel: one item = four 16-bit channel values in s_tdata, chan0 lowest.
// Master channel: one byte per item on m_tdata; ten bytes per frame: each channel
// low byte then high byte in channel order, then CRC low, CRC high. m_tlast marks
// the CRC high byte.
// CRC: preset 0xFFFF, reflected polynomial 0xA001, no final xor, over the eight
// data bytes; nothing carries over between frames.
// The first byte of a frame becomes valid once its item has passed through the
// pipeline (one pipeline stage per channel, one byte-table CRC step pair each)
// and then the output serializer register.
// Throughput: the serializer sends one byte per cycle while m_tready is high; the
// next frame loads in the same cycle its predecessor's last byte leaves.
// The pipeline keeps accepting items until all four stages are full.
// Stall: when m_tready is low the current byte holds and the pipeline backs up;
// nothing is lost or repeated.
// Reset (rst_n low, async): all valid bits and the serializer clear; in-flight
// frames are dropped.
module scope_frame_crc16_encoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // chan0_value, chan1_value, chan2_value, chan3_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // frame_byte
    output logic             m_tlast    // last_byte
);
    import scfc_pkg::*;

    logic       stg_valid [CHANNELS+1];
    logic       stg_ready [CHANNELS+1];
    scfc_item_t stg_item  [CHANNELS+1];

    assign stg_valid[0]     = s_tvalid;
    assign s_tready         = stg_ready[0];
    assign stg_item[0].chan = s_tdata;
    assign stg_item[0].crc  = CRC_PRESET;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_stage
        scfc_stage u_stage
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (stg_valid[g]),
            .in_ready   (stg_ready[g]),
            .in_item    (stg_item[g]),
            .chan_value (stg_item[g].chan[g]),
            .out_valid  (stg_valid[g+1]),
            .out_ready  (stg_ready[g+1]),
            .out_item   (stg_item[g+1])
        );
    end

    scfc_serializer u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[CHANNELS]),
        .in_ready (stg_ready[CHANNELS]),
        .in_item  (stg_item[CHANNELS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
